/* design/ibt_pkg.sv */
package ibt_pkg;

    // Control states of the table sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef logic [1:0] op_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_LOOKUP = 2'd0;
    localparam op_t OP_ADD    = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;

    localparam status_t STAT_LOOKED_UP   = 3'd0;
    localparam status_t STAT_ADDED       = 3'd1;
    localparam status_t STAT_ALREADY     = 3'd2;
    localparam status_t STAT_FULL        = 3'd3;
    localparam status_t STAT_REMOVED     = 3'd4;
    localparam status_t STAT_NOT_LISTED  = 3'd5;
    localparam status_t STAT_SUBNET_ONLY = 3'd6;

    localparam int ADDR_W = 32;

    // Entry with a zero last octet covers the whole /24
    function automatic logic entry_match(logic [ADDR_W-1:0] ent, logic [ADDR_W-1:0] addr);
        logic is_subnet;
        is_subnet = (ent[7:0] == 8'd0);
        if (is_subnet)
            return ent[ADDR_W-1:8] == addr[ADDR_W-1:8];
        else
            return ent == addr;
    endfunction

endpackage

/* design/ip_ban_table_core.sv */
// IPv4 ban table with /24 subnet entries.
// Channels:
//   s_axis: one transaction per operation. tuser carries the op code
//           (lookup, add, remove; the unused code acts as a lookup), tdata
//           carries the 32-bit address.
//   m_axis: one transaction per operation with the verdict, the status code
//           and the number of valid entries after the operation.
//   APB:    register 0 at byte address 0 holds filter_mode (bit 0).
// Scan: every operation scans all TABLE_ENTRIES slots of the entry memory
// through its single read port, one slot per cycle, in ST_SCAN, and then
// loads its result into the output register in ST_COMMIT. A new operation
// is taken in the cycle after the result is loaded.
// Reset: filter_mode returns to 1 and the entry count to zero. A clearing
// pass then writes every slot of the memory invalid, one slot a cycle;
// s_axis_tready stays low meanwhile. APB writes are taken at any time.
// Stall: a finished result waits in the output register while the next
// operation is accepted and scanned; the commit of that next operation
// holds until the output register is free.
module ip_ban_table_core
    import ibt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] ip_addr
    input  logic [1:0]  s_axis_tuser,   // [1:0] op

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] banned, [3:1] status,
                                        // [10:4] entry_count, [15:11] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNTW-1:0] LAST_SLOT = CNTW'(TABLE_ENTRIES - 1);
    localparam logic [CNTW-1:0] NUM_SLOTS = CNTW'(TABLE_ENTRIES);
    localparam int WORD_W = ADDR_W + 1;

    // Entry memory: {valid, address}; subnet flag follows from the address
    logic [WORD_W-1:0] entry_mem [TABLE_ENTRIES];

    state_t            state_reg, state_next;
    logic [CNTW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDXW-1:0]   rd_idx_reg;
    logic [WORD_W-1:0] rd_data_reg;

    op_t               op_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              hit_reg, hit_next;
    logic              free_found_reg, free_found_next;
    logic [IDXW-1:0]   free_idx_reg, free_idx_next;
    logic              exact_found_reg, exact_found_next;
    logic [IDXW-1:0]   exact_idx_reg, exact_idx_next;

    logic [CNTW-1:0]   count_reg, count_next;
    logic              filter_mode_reg;

    logic              m_valid_reg, m_valid_next;
    logic              out_banned_reg, out_banned_next;
    status_t           out_status_reg, out_status_next;
    logic [6:0]        out_count_reg, out_count_next;

    logic              mem_we;
    logic [IDXW-1:0]   mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDXW-1:0]   rd_addr;
    logic              s_accept;
    logic              cfg_write;
    logic [CNTW+6:0]   count_ext;

    logic              ent_valid;
    logic [ADDR_W-1:0] ent_addr;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign rd_addr       = scan_cnt_reg[IDXW-1:0];
    assign ent_valid     = rd_data_reg[WORD_W-1];
    assign ent_addr      = rd_data_reg[ADDR_W-1:0];
    assign count_ext     = {7'd0, count_next};

    // APB: single register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = {31'd0, filter_mode_reg};

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, out_count_reg, out_status_reg, out_banned_reg};

    // Sequencer: clear pass, idle, scan all slots, commit result
    always_comb
    begin
        state_next       = state_reg;
        scan_cnt_next    = scan_cnt_reg;
        rd_vld_next      = 1'b0;
        hit_next         = hit_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        exact_found_next = exact_found_reg;
        exact_idx_next   = exact_idx_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        out_banned_next  = out_banned_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = scan_cnt_reg[IDXW-1:0];
        mem_wdata        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (scan_cnt_reg == LAST_SLOT)
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    scan_cnt_next    = '0;
                    hit_next         = 1'b0;
                    free_found_next  = 1'b0;
                    exact_found_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read a cycle, evaluate the slot read last cycle
                if (scan_cnt_reg < NUM_SLOTS)
                begin
                    rd_vld_next   = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end

                if (rd_vld_reg)
                begin
                    if (ent_valid && entry_match(ent_addr, addr_reg))
                        hit_next = 1'b1;
                    if (!ent_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (ent_valid && (ent_addr == addr_reg) && !exact_found_reg)
                    begin
                        exact_found_next = 1'b1;
                        exact_idx_next   = rd_idx_reg;
                    end
                end
            end

            ST_COMMIT:
            begin
                // Hold until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_banned_next = 1'b0;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (hit_reg)
                                out_status_next = STAT_ALREADY;
                            else if (free_found_reg)
                            begin
                                out_status_next = STAT_ADDED;
                                mem_we          = 1'b1;
                                mem_waddr       = free_idx_reg;
                                mem_wdata       = {1'b1, addr_reg};
                                count_next      = count_reg + 1'b1;
                            end
                            else
                                out_status_next = STAT_FULL;
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_reg)
                                out_status_next = STAT_NOT_LISTED;
                            else if (exact_found_reg)
                            begin
                                out_status_next = STAT_REMOVED;
                                mem_we          = 1'b1;
                                mem_waddr       = exact_idx_reg;
                                mem_wdata       = {1'b0, addr_reg};
                                count_next      = count_reg - 1'b1;
                            end
                            else
                                out_status_next = STAT_SUBNET_ONLY;
                        end
                        default:
                        begin
                            out_status_next = STAT_LOOKED_UP;
                            out_banned_next = filter_mode_reg ? hit_reg : !hit_reg;
                        end
                    endcase
                    out_count_next = count_ext[6:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            scan_cnt_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            exact_found_reg <= 1'b0;
            count_reg       <= '0;
            filter_mode_reg <= 1'b1;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_cnt_reg    <= scan_cnt_next;
            rd_vld_reg      <= rd_vld_next;
            hit_reg         <= hit_next;
            free_found_reg  <= free_found_next;
            exact_found_reg <= exact_found_next;
            count_reg       <= count_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_write)
                filter_mode_reg <= pwdata[0];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg   <= s_axis_tuser;
            addr_reg <= s_axis_tdata;
        end
        rd_idx_reg     <= rd_addr;
        free_idx_reg   <= free_idx_next;
        exact_idx_reg  <= exact_idx_next;
        out_banned_reg <= out_banned_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= entry_mem[rd_addr];
    end

endmodule

/* design/ibt_checker.sv */
module ibt_checker
    import ibt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic    out_banned;
    status_t out_status;

    assign out_banned = m_axis_tdata[0];
    assign out_status = m_axis_tdata[3:1];

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Status code stays within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> out_status <= STAT_SUBNET_ONLY)
        else $error("undefined status code");

    // Only a lookup reports a ban verdict
    a_banned_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_banned |-> out_status == STAT_LOOKED_UP)
        else $error("banned set on add or remove");

    // A table scan follows every accepted transaction
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted during scan");

endmodule

bind ip_ban_table_core ibt_checker u_ibt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
